[sv/alt_pkg.sv]
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and constants for the array linked list table.
// ----------------------------------------------------------------------------
package alt_pkg;

    localparam int SLOTS         = 64;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int IDX_W         = $clog2(SLOTS);

    // input word: payload, slot (func travels on tuser)
    localparam int IN_BITS   = PAYLOAD_WIDTH + IDX_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // result word: status, slot_index, payload_out, next_slot, is_last,
    // head_slot, tail_slot, list_empty, list_full
    localparam int OUT_BITS    = 2 + IDX_W + PAYLOAD_WIDTH + IDX_W + 1 + IDX_W + IDX_W + 2;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_REMOVE = 2'd1,
        FN_READ   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    // one entry of the link memory
    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] nxt;
    } link_t;

    // control toward the used-flag block
    typedef struct packed {
        logic             wr_en;
        logic             wr_val;
        logic [IDX_W-1:0] wr_idx;
        logic             scan_start;
    } used_cmd_t;

    // status from the used-flag block
    typedef struct packed {
        logic             busy;
        logic             full;
        logic [IDX_W-1:0] free_ptr;
    } used_sts_t;

endpackage

[sv/array_linked_list_table.sv]
// ----------------------------------------------------------------------------
// array_linked_list_table
// Singly linked list kept in a fixed slot array: append, remove, read.
// ----------------------------------------------------------------------------
//  channel | ports                        | fields (lowest bit up)
//  --------+------------------------------+----------------------------------
//  request | s_tvalid s_tready s_tdata    | tdata: payload, slot
//          | s_tuser                      | tuser: func
//  result  | m_tvalid m_tready m_tdata    | tdata: status, slot_index,
//          |                              |   payload_out, next_slot, is_last,
//          |                              |   head_slot, tail_slot,
//          |                              |   list_empty, list_full
//
//  One word at a time. Read: RAM read, capture into the item registers, then the
//  output register. Append: a link step when it hooks after an existing tail,
//  then the free-slot scan (one flag per cycle). Remove: up to SLOTS reads of
//  the single-port link RAM while walking for the predecessor, then the scan.
//  A finished result waits in the output register while the next word is
//  taken; the next result then holds until that register drains.
//  Reset (aresetn low, synchronous) clears all occupancy flags at once; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
module array_linked_list_table (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [alt_pkg::IN_TDATA_W-1:0]      s_tdata,  // payload, slot
    input  logic [1:0]                          s_tuser,  // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [alt_pkg::OUT_TDATA_W-1:0]     m_tdata   // status, slot_index,
                                                           // payload_out, next_slot,
                                                           // is_last, head_slot,
                                                           // tail_slot, list_empty,
                                                           // list_full
);
    import alt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_APP_LINK,
        S_REM_S,
        S_WALK,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;

    // list registers
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic             empty_reg;

    // item in flight
    logic [IDX_W-1:0]         slot_reg;
    link_t                    sl_link_reg;
    logic [IDX_W-1:0]         cur_reg;
    logic [IDX_W-1:0]         step_reg;
    status_t                  status_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [PAYLOAD_WIDTH-1:0] pout_reg;
    logic [IDX_W-1:0]         nxt_reg;
    logic                     last_reg;

    // output register
    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // request fields
    func_t                    in_func;
    logic [PAYLOAD_WIDTH-1:0] in_payload;
    logic [IDX_W-1:0]         in_slot;
    logic                     accept;

    assign in_func    = func_t'(s_tuser);
    assign in_payload = s_tdata[PAYLOAD_WIDTH-1:0];
    assign in_slot    = s_tdata[PAYLOAD_WIDTH +: IDX_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;

    // memories
    logic                     pay_we;
    logic [IDX_W-1:0]         pay_addr;
    logic [PAYLOAD_WIDTH-1:0] pay_rdata;
    logic                     link_we;
    logic [IDX_W-1:0]         link_addr;
    link_t                    link_wdata;
    link_t                    link_rdata;

    // occupancy
    used_cmd_t        used_cmd;
    used_sts_t        used_sts;
    logic [IDX_W-1:0] used_rd_idx;
    logic             used_hit;

    alt_ram #(
        .WIDTH (PAYLOAD_WIDTH),
        .DEPTH (SLOTS)
    ) u_pay_ram (
        .clk   (aclk),
        .we    (pay_we),
        .addr  (pay_addr),
        .wdata (in_payload),
        .rdata (pay_rdata)
    );

    alt_ram #(
        .WIDTH ($bits(link_t)),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (aclk),
        .we    (link_we),
        .addr  (link_addr),
        .wdata (link_wdata),
        .rdata (link_rdata)
    );

    alt_used u_used (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (used_cmd),
        .rd_idx  (used_rd_idx),
        .rd_used (used_hit),
        .sts     (used_sts)
    );

    assign used_rd_idx = (state_reg == S_IDLE) ? in_slot : slot_reg;

    // walk decisions on the link word just read
    logic walk_found;
    logic walk_limit;
    assign walk_found = !link_rdata.last && (link_rdata.nxt == slot_reg);
    assign walk_limit = (step_reg == IDX_W'(SLOTS - 1));

    logic out_load;
    assign out_load = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    // memory and occupancy controls
    always_comb begin
        pay_we     = 1'b0;
        pay_addr   = '0;
        link_we    = 1'b0;
        link_addr  = '0;
        link_wdata = '0;
        used_cmd   = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    case (in_func)
                        FN_APPEND: begin
                            if (!used_sts.full) begin
                                // store payload and a terminal link in the free slot
                                pay_we          = 1'b1;
                                pay_addr        = used_sts.free_ptr;
                                link_we         = 1'b1;
                                link_addr       = used_sts.free_ptr;
                                link_wdata.last = 1'b1;
                                link_wdata.nxt  = '0;
                                used_cmd.wr_en  = 1'b1;
                                used_cmd.wr_val = 1'b1;
                                used_cmd.wr_idx = used_sts.free_ptr;
                                used_cmd.scan_start = empty_reg;
                            end
                        end
                        FN_REMOVE: begin
                            link_addr = in_slot;
                        end
                        FN_READ: begin
                            pay_addr  = in_slot;
                            link_addr = in_slot;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_APP_LINK: begin
                // hook the new slot after the old tail
                link_we             = 1'b1;
                link_addr           = tail_reg;
                link_wdata.last     = 1'b0;
                link_wdata.nxt      = idx_reg;
                used_cmd.scan_start = 1'b1;
            end
            S_REM_S: begin
                if (slot_reg == head_reg) begin
                    used_cmd.wr_en      = 1'b1;
                    used_cmd.wr_idx     = slot_reg;
                    used_cmd.scan_start = 1'b1;
                end else begin
                    link_addr = head_reg;
                end
            end
            S_WALK: begin
                if (walk_found) begin
                    // unlink: predecessor takes over the removed slot's link
                    link_we   = 1'b1;
                    link_addr = cur_reg;
                    if (slot_reg == tail_reg) begin
                        link_wdata.last = 1'b1;
                        link_wdata.nxt  = slot_reg;
                    end else begin
                        link_wdata = sl_link_reg;
                    end
                    used_cmd.wr_en      = 1'b1;
                    used_cmd.wr_idx     = slot_reg;
                    used_cmd.scan_start = 1'b1;
                end else begin
                    link_addr = link_rdata.nxt;
                end
            end
            default: begin
            end
        endcase
    end

    // sequencer, list registers and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        slot_reg   <= in_slot;
                        status_reg <= ST_OK;
                        idx_reg    <= '0;
                        pout_reg   <= '0;
                        nxt_reg    <= '0;
                        last_reg   <= 1'b0;
                        case (in_func)
                            FN_APPEND: begin
                                if (used_sts.full) begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    idx_reg <= used_sts.free_ptr;
                                    if (empty_reg) begin
                                        head_reg  <= used_sts.free_ptr;
                                        tail_reg  <= used_sts.free_ptr;
                                        empty_reg <= 1'b0;
                                        state_reg <= S_SCAN;
                                    end else begin
                                        state_reg <= S_APP_LINK;
                                    end
                                end
                            end
                            FN_REMOVE: begin
                                idx_reg <= in_slot;
                                if (!used_hit) begin
                                    status_reg <= ST_ABSENT;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    state_reg <= S_REM_S;
                                end
                            end
                            FN_READ: begin
                                idx_reg <= in_slot;
                                if (!used_hit) begin
                                    status_reg <= ST_ABSENT;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    state_reg <= S_RD_WAIT;
                                end
                            end
                            default: begin
                                state_reg <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    pout_reg  <= pay_rdata;
                    last_reg  <= link_rdata.last;
                    nxt_reg   <= link_rdata.last ? '0 : link_rdata.nxt;
                    state_reg <= S_EMIT;
                end
                S_APP_LINK: begin
                    tail_reg  <= idx_reg;
                    state_reg <= S_SCAN;
                end
                S_REM_S: begin
                    sl_link_reg <= link_rdata;
                    if (slot_reg == head_reg) begin
                        if (slot_reg == tail_reg || link_rdata.last) begin
                            head_reg  <= '0;
                            tail_reg  <= '0;
                            empty_reg <= 1'b1;
                        end else begin
                            head_reg <= link_rdata.nxt;
                        end
                        state_reg <= S_SCAN;
                    end else begin
                        cur_reg   <= head_reg;
                        step_reg  <= '0;
                        state_reg <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (link_rdata.last) begin
                        status_reg <= ST_ABSENT;
                        state_reg  <= S_EMIT;
                    end else if (walk_found) begin
                        if (slot_reg == tail_reg) begin
                            tail_reg <= cur_reg;
                        end
                        state_reg <= S_SCAN;
                    end else if (walk_limit) begin
                        status_reg <= ST_ABSENT;
                        state_reg  <= S_EMIT;
                    end else begin
                        // advance to the successor
                        cur_reg  <= link_rdata.nxt;
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (!used_sts.busy) begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {
                            (OUT_TDATA_W - OUT_BITS)'(0),
                            used_sts.full,
                            empty_reg,
                            tail_reg,
                            head_reg,
                            last_reg,
                            nxt_reg,
                            pout_reg,
                            idx_reg,
                            status_reg
                        };
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_reg |-> (head_reg == '0 && tail_reg == '0))
        else $error("empty list with nonzero head or tail");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("second word taken while one is in flight");

    a_no_publish_mid_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> !used_sts.busy)
        else $error("result published while free scan still running");

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> !empty_reg)
        else $error("walking an empty list");
`endif

endmodule

[sv/alt_ram.sv]
// ----------------------------------------------------------------------------
// alt_ram
// Single-port synchronous RAM, registered read, read-first.
// ----------------------------------------------------------------------------
module alt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[sv/alt_used.sv]
// ----------------------------------------------------------------------------
// alt_used
// Slot occupancy flags and a lowest-free-slot scanner, one flag per cycle.
// ----------------------------------------------------------------------------
module alt_used (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  alt_pkg::used_cmd_t       cmd,
    input  logic [alt_pkg::IDX_W-1:0] rd_idx,
    output logic                     rd_used,
    output alt_pkg::used_sts_t       sts
);
    import alt_pkg::*;

    logic [SLOTS-1:0] used_reg;
    logic             scanning_reg;
    logic [IDX_W-1:0] scan_cnt_reg;
    logic [IDX_W-1:0] free_ptr_reg;
    logic             full_reg;

    assign rd_used      = used_reg[rd_idx];
    assign sts.busy     = scanning_reg;
    assign sts.full     = full_reg;
    assign sts.free_ptr = free_ptr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg     <= '0;
            scanning_reg <= 1'b0;
            scan_cnt_reg <= '0;
            free_ptr_reg <= '0;
            full_reg     <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                used_reg[cmd.wr_idx] <= cmd.wr_val;
            end
            if (cmd.scan_start) begin
                scanning_reg <= 1'b1;
                scan_cnt_reg <= '0;
            end else if (scanning_reg) begin
                if (!used_reg[scan_cnt_reg]) begin
                    free_ptr_reg <= scan_cnt_reg;
                    full_reg     <= 1'b0;
                    scanning_reg <= 1'b0;
                end else if (scan_cnt_reg == IDX_W'(SLOTS - 1)) begin
                    free_ptr_reg <= '0;
                    full_reg     <= 1'b1;
                    scanning_reg <= 1'b0;
                end else begin
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule
